// ===== sv/dct_8x8_forward_top_assert.svh =====
// Assertion macros for the 8x8 forward DCT
`ifndef DCT_8X8_FORWARD_TOP_ASSERT_SVH
`define DCT_8X8_FORWARD_TOP_ASSERT_SVH
// implication check sampled on clk, quiet during reset
`define DCT_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication check
`define DCT_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== sv/dct_pkg.sv =====
// ----------------------------------------------------------------------------
// dct_pkg
// Shared constants and basis function for the 8x8 forward DCT.
// ----------------------------------------------------------------------------
package dct_pkg;
  localparam int BLOCK_DIM      = 8;
  localparam int COEF_FRAC_BITS = 4;
  localparam int BASIS_FRAC     = 14;
  localparam int SHIFT          = 2 * BASIS_FRAC + 2 - COEF_FRAC_BITS;

  // basis B(k,m) = round(2^14 * n(k) * cos(k(2m+1)pi/16))
  function automatic logic signed [15:0] basis(input logic [2:0] k, input logic [2:0] m);
    logic [4:0] a;
    logic [15:0] mag;
    logic [3:0] idx;
    logic neg;
    // angle index mod 32, product taken at 5 bits
    a   = {2'b00, k} * {1'b0, m, 1'b1};
    neg = 1'b0;
    if (a > 5'd16) a = 5'(6'd32 - {1'b0, a});
    idx = a[3:0];
    if (a > 5'd8) begin
      neg = 1'b1;
      idx = 4'(5'd16 - a);
    end
    case (idx)
      4'd0: mag = 16'd16384;
      4'd1: mag = 16'd16069;
      4'd2: mag = 16'd15137;
      4'd3: mag = 16'd13623;
      4'd4: mag = 16'd11585;
      4'd5: mag = 16'd9102;
      4'd6: mag = 16'd6270;
      4'd7: mag = 16'd3196;
      default: mag = 16'd0;
    endcase
    if (k == 3'd0) return 16'sd11585;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction
endpackage

// ===== sv/dct_mac.sv =====
// ----------------------------------------------------------------------------
// dct_mac
// One multiply-accumulate lane with a registered product.
// ----------------------------------------------------------------------------
module dct_mac import dct_pkg::*; (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [15:0] b,
  output logic signed [51:0] acc
);
  logic signed [47:0] prod;
  logic               en_d;
  logic               clr_d;

  always_ff @(posedge clk) begin
    prod  <= 48'(a) * 48'(b);
    en_d  <= en;
    clr_d <= clr;
    if (en_d) begin
      acc <= (clr_d ? 52'sd0 : acc) + 52'(prod);
    end
  end
endmodule

// ===== sv/dct_8x8_forward_top.sv =====
// ----------------------------------------------------------------------------
// dct_8x8_forward_top
// 8x8 two-dimensional forward DCT-II, memory based, one shared MAC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: sample (9-bit signed) with in_valid / in_stall, one beat
//   per sample, 64 beats per block in row-major order.
//   Output channel: coefficient, freq_row, freq_col, last with out_valid /
//   out_stall, 64 beats per block, row-major (j, i), last on the 64th.
//   Samples load one per cycle while in_valid is high into a 64-entry sample
//   memory. After the 64th the row pass runs 64 outputs x 8 MAC steps into a
//   part memory, then the column pass does the same per coefficient, each
//   coefficient going to an output register. Each MAC step reads one memory
//   word (registered read); all coefficients go through the single multiplier
//   one after another, and in the column pass each one waits in the output
//   register until it is taken.
//   in_stall is high from the 64th sample until the last coefficient leaves.
//   When out_stall is high the column pass holds with its result parked.
//   Reset (rst, synchronous) returns to loading with an empty block.
module dct_8x8_forward_top import dct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [8:0] sample,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [15:0] coefficient,
  output logic [2:0]        freq_row,
  output logic [2:0]        freq_col,
  output logic              last
);
  localparam logic [1:0] S_LOAD = 2'd0, S_ROW = 2'd1, S_COL = 2'd2, S_OUT = 2'd3;

  logic [1:0]  state;
  logic [5:0]  wcnt;
  logic [5:0]  outer;   // target index (row: y*8+i, col: j*8+i)
  logic [3:0]  step;    // 0..7 issue, then drain
  logic signed [8:0]  smem [64];
  logic signed [31:0] pmem [64];
  logic signed [8:0]  s_rd;
  logic signed [31:0] p_rd;
  logic        rd_v;
  logic [2:0]  rd_k;
  logic signed [31:0] mac_a;
  logic signed [15:0] mac_b;
  logic        mac_clr;
  logic signed [51:0] acc;
  logic        load_fire;
  logic [5:0]  raddr;
  logic        acc_done;
  logic signed [51:0] mag;
  logic signed [51:0] rnd;

  assign in_stall  = (state != S_LOAD);
  assign load_fire = in_valid && !in_stall;

  // memory read address: row pass reads sample[y][x], column pass part[y][i]
  always_comb begin
    if (state == S_ROW) raddr = {outer[5:3], step[2:0]};
    else                raddr = {step[2:0], outer[2:0]};
  end

  always_ff @(posedge clk) begin
    if (load_fire) smem[wcnt] <= sample;
    s_rd <= smem[raddr];
    p_rd <= pmem[raddr];
  end

  // read result feeds the MAC in the cycle after issue
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= (state == S_ROW || state == S_COL) && !step[3];
    end
    rd_k <= step[2:0];
  end

  always_comb begin
    if (state == S_ROW) begin
      mac_a = 32'(s_rd);
      mac_b = basis(outer[2:0], rd_k);
    end else begin
      mac_a = p_rd;
      mac_b = basis(outer[5:3], rd_k);
    end
  end
  assign mac_clr = (rd_k == 3'd0);

  dct_mac u_mac (
    .clk (clk), .clr (mac_clr), .en (rd_v), .a (mac_a), .b (mac_b), .acc (acc)
  );

  // read at step 0..7, MAC product at 2..9, acc valid after step 10
  assign acc_done = (step == 4'd11);

  // rounding: to nearest, ties away from zero, then saturate
  always_comb begin
    mag = acc[51] ? -acc : acc;
    rnd = (mag + (52'sd1 <<< (SHIFT - 1))) >>> SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      wcnt      <= 6'd0;
      outer     <= 6'd0;
      step      <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (load_fire) begin
            wcnt <= wcnt + 6'd1;
            if (wcnt == 6'd63) begin
              state <= S_ROW;
              outer <= 6'd0;
              step  <= 4'd0;
            end
          end
        end
        S_ROW: begin
          if (acc_done) begin
            pmem[outer] <= acc[31:0];
            step  <= 4'd0;
            outer <= outer + 6'd1;
            if (outer == 6'd63) state <= S_COL;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_COL: begin
          if (acc_done) begin
            step      <= 4'd0;
            state     <= S_OUT;
            out_valid <= 1'b1;
            freq_row  <= outer[5:3];
            freq_col  <= outer[2:0];
            last      <= (outer == 6'd63);
            if (acc[51]) begin
              coefficient <= (rnd > 52'sd32768) ? -16'sd32768 : 16'(-rnd);
            end else begin
              coefficient <= (rnd > 52'sd32767) ? 16'sd32767 : 16'(rnd);
            end
          end else begin
            step <= step + 4'd1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            outer     <= outer + 6'd1;
            state     <= (outer == 6'd63) ? S_LOAD : S_COL;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== sv/dct_8x8_forward_check.sv =====
// ----------------------------------------------------------------------------
// dct_8x8_forward_check
// Port-level checks for the 8x8 forward DCT.
// ----------------------------------------------------------------------------
`include "dct_8x8_forward_top_assert.svh"
module dct_8x8_forward_check (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [15:0] coefficient,
  input logic [2:0]        freq_row,
  input logic [2:0]        freq_col,
  input logic              last
);
  `DCT_ASSERT_IMP(a_no_in_while_out, out_valid, in_stall, "input open during output")
  `DCT_ASSERT_IMP(a_last_idx, out_valid && last, freq_row == 3'd7 && freq_col == 3'd7,
                  "last on wrong index")
  `DCT_ASSERT_NXT(a_hold, out_valid && out_stall,
                  out_valid && $stable(coefficient) && $stable(freq_col), "beat changed")
  `DCT_ASSERT_NXT(a_last_end, out_valid && !out_stall && last, !in_stall,
                  "load not reopened")
endmodule

bind dct_8x8_forward_top dct_8x8_forward_check u_check (
  .clk (clk), .rst (rst), .in_stall (in_stall),
  .out_valid (out_valid), .out_stall (out_stall), .coefficient (coefficient),
  .freq_row (freq_row), .freq_col (freq_col), .last (last)
);

// ===== dv/dct_8x8_forward_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_8x8_forward_top_test
// Self-checking bench for the 8x8 forward DCT: streams sample blocks, predicts
// each coefficient in exact integer arithmetic and compares every beat.
// ----------------------------------------------------------------------------
module dct_8x8_forward_top_test;
  import dct_pkg::*;

  localparam int BLOCK_SAMPLES = 64;
  localparam int IDLE_LIMIT    = 20000;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic signed [15:0] coefficient;
    logic [2:0]         freq_row;
    logic [2:0]         freq_col;
    logic               last;
  } coef_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic signed [8:0] sample = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [15:0] coefficient;
  logic [2:0]        freq_row;
  logic [2:0]        freq_col;
  logic              last;

  coef_beat_t        coef_queue[$];
  logic signed [8:0] block_buf[BLOCK_SAMPLES];
  int                fill_count = 0;
  int                mismatch_count = 0;
  int                beats_sent = 0;
  int                coefs_checked = 0;
  int                blocks_done = 0;
  int                idle_cycles = 0;
  int                burst_left = 0;
  int                stall_mode = 0;
  bit                run_done = 1'b0;

  dct_8x8_forward_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .coefficient(coefficient), .freq_row(freq_row), .freq_col(freq_col), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // own cosine table, 14 fractional bits, normalization folded in
  function automatic longint cos_weight(int k, int m);
    int a;
    longint mag[9] = '{16384, 16069, 15137, 13623, 11585, 9102, 6270, 3196, 0};
    if (k == 0) return 11585;
    a = (k * (2 * m + 1)) % 32;
    if (a > 16) a = 32 - a;
    if (a > 8) return -mag[16 - a];
    return mag[a];
  endfunction

  function automatic logic signed [15:0] scale_coef(longint acc);
    int     sh;
    longint mag;
    sh  = 2 * 14 + 2 - COEF_FRAC_BITS;
    mag = (acc < 0) ? -acc : acc;
    mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
    if (acc < 0) return (mag > 32768) ? -16'sd32768 : 16'(-mag);
    return (mag > 32767) ? 16'sd32767 : 16'(mag);
  endfunction

  // row-column transform of a full block into the expected coefficient list
  task automatic predict_block();
    longint    row_part[8][8];
    longint    acc;
    coef_beat_t c;
    for (int y = 0; y < 8; y++)
      for (int i = 0; i < 8; i++) begin
        acc = 0;
        for (int x = 0; x < 8; x++) acc += longint'(block_buf[y * 8 + x]) * cos_weight(i, x);
        row_part[y][i] = acc;
      end
    for (int j = 0; j < 8; j++)
      for (int i = 0; i < 8; i++) begin
        acc = 0;
        for (int y = 0; y < 8; y++) acc += cos_weight(j, y) * row_part[y][i];
        c.coefficient = scale_coef(acc);
        c.freq_row    = 3'(j);
        c.freq_col    = 3'(i);
        c.last        = (j == 7 && i == 7);
        coef_queue.push_back(c);
      end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d (coef %0d)", what, got, want, coefs_checked);
    mismatch_count++;
  endtask

  // one sample beat, with bursty gaps ahead of it
  task automatic send_sample(logic signed [8:0] val);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample   <= val;
    do @(posedge clk); while (in_stall);
    block_buf[fill_count] = val;
    fill_count++;
    beats_sent++;
    if (fill_count == BLOCK_SAMPLES) begin
      predict_block();
      fill_count = 0;
      blocks_done++;
    end
  endtask

  task automatic send_block_const(logic signed [8:0] val);
    for (int n = 0; n < BLOCK_SAMPLES; n++) send_sample(val);
  endtask

  // directed: extremes and sign patterns, flat blocks hit the DC rounding and come near its limit
  task automatic test_extremes();
    send_block_const(9'sd255);
    send_block_const(-9'sd256);
    for (int n = 0; n < BLOCK_SAMPLES; n++)
      send_sample((((n / 8) + (n % 8)) % 2) ? 9'sd255 : -9'sd256);
  endtask

  task automatic test_random_blocks();
    int kind;
    for (int b = 0; b < 1; b++) begin
      kind = $urandom_range(0, 2);
      for (int n = 0; n < BLOCK_SAMPLES; n++)
        case (kind)
          0: send_sample(9'($urandom));
          1: send_sample(($urandom_range(0, 1)) ? 9'sd255 : -9'sd256);
          default: send_sample(9'(int'($urandom_range(0, 40)) - 20));
        endcase
    end
  endtask

  // receiver: stall pattern switches between none, sparse random and dense random
  always @(posedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    coef_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (coef_queue.size() == 0) begin
        report_mismatch("unexpected beat", coefficient, 0);
      end else begin
        want = coef_queue.pop_front();
        if (coefficient !== want.coefficient)
          report_mismatch("coefficient", coefficient, want.coefficient);
        if (freq_row !== want.freq_row) report_mismatch("freq_row", freq_row, want.freq_row);
        if (freq_col !== want.freq_col) report_mismatch("freq_col", freq_col, want.freq_col);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
      coefs_checked++;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || run_done || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("dct_8x8_forward_top_test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random_blocks();
    in_valid <= 1'b0;
    while (coef_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done = 1'b1;
    $display("covered %0d samples in %0d blocks, %0d coefficients checked",
             beats_sent, blocks_done, coefs_checked);
    if (mismatch_count == 0 && coef_queue.size() == 0)
      $display("dct_8x8_forward_top_test passed");
    else
      $display("dct_8x8_forward_top_test failed");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/dct_pkg.sv
sv/dct_mac.sv
sv/dct_8x8_forward_top.sv
sv/dct_8x8_forward_check.sv
dv/dct_8x8_forward_top_test.sv
